// ===== sv/pcl_pkg.sv =====
`default_nettype none
package pcl_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // field widths
  localparam int OFF_W   = 32;
  localparam int LINE_W  = 24;
  localparam int EIDX_W  = 10;
  localparam int CNT_W   = 11;
  localparam int REC_W   = OFF_W + LINE_W;

  // stream payload widths
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 40;

  // request kinds carried in tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // register indexes
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_HAS   = 2'd2;
  localparam logic [1:0] REG_IMPL  = 2'd3;

endpackage
`default_nettype wire

// ===== sv/pc_to_line_lookup_top.sv =====
`default_nettype none
// pc to source line lookup
// in_ channel: one beat is either a load (tuser = 0) that writes one line
//   record (start offset, line) into the table, or a query (tuser = 1) that
//   carries a pc. A load produces no result.
// out_ channel: one beat per query with the line, slot and impl-part flag
//   of the last record whose offset is at most pc - base_address, or of record 0 if none is.
// cfg_ port: APB-style, base_address, entry_count, has_impl_part and
//   impl_offset at byte addresses 0, 4, 8, 12; pready is tied high.
// search: the accept issues the first record read; each probe step compares
//   the read offset with the key and issues the next read, ending on the found
//   record; the line-read step then loads the output register. A single record
//   needs no probe step, and the next beat is taken after the line-read step.
// one query is in flight at a time; each probe is one read of the record RAM.
// reset clears the registers to 0, 1, 0, 0 and the control state; the
//   record table is not cleared and must be loaded before it is queried.
// when the receiver stalls, the result waits in the output register and a
//   finished search holds in its last step until that register frees up.
module pc_to_line_lookup_top
  import pcl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in tdata: entry_index[9:0], entry_offset[41:10], entry_line[65:42], pc[97:66]
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // in tuser: req_type[0]
  input  wire logic                  in_tuser,
  // out tdata: line_number[23:0], found_index[33:24], in_impl_part[34]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [3:0]            cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic      [31:0]           cfg_prdata,
  output logic                       cfg_pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_LINE = 2'd2;

  // input fields
  logic              req_type;
  logic [EIDX_W-1:0] entry_index;
  logic [OFF_W-1:0]  entry_offset;
  logic [LINE_W-1:0] entry_line;
  logic [OFF_W-1:0]  pc;

  assign req_type     = in_tuser;
  assign entry_index  = in_tdata[9:0];
  assign entry_offset = in_tdata[41:10];
  assign entry_line   = in_tdata[65:42];
  assign pc           = in_tdata[97:66];

  // configuration registers
  logic [OFF_W-1:0] base_r;
  logic [CNT_W-1:0] count_r;
  logic             has_impl_r;
  logic [OFF_W-1:0] impl_off_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      count_r    <= CNT_W'(1);
      has_impl_r <= 1'b0;
      impl_off_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_BASE:  base_r     <= cfg_pwdata;
        REG_COUNT: count_r    <= cfg_pwdata[CNT_W-1:0];
        REG_HAS:   has_impl_r <= cfg_pwdata[0];
        REG_IMPL:  impl_off_r <= cfg_pwdata;
        default:   ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_paddr[3:2])
      REG_BASE:  cfg_prdata = base_r;
      REG_COUNT: cfg_prdata = 32'(count_r);
      REG_HAS:   cfg_prdata = 32'(has_impl_r);
      REG_IMPL:  cfg_prdata = impl_off_r;
      default:   cfg_prdata = '0;
    endcase
  end

  // search state
  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  lo_r, lo_nxt;
  logic [IDX_W-1:0]  hi_r, hi_nxt;
  logic [IDX_W-1:0]  mid_r, mid_nxt;
  logic [OFF_W-1:0]  key_r, key_nxt;
  logic              impl_r, impl_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // record memory
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [REC_W-1:0] ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [REC_W-1:0] ram_rdata;

  logic             in_acc;
  logic             idx_ok;
  logic [31:0]      cnt32;
  logic [IDX_W-1:0] hi_init;
  logic [OFF_W-1:0] key_in;
  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] lo_c, hi_c;
  logic             out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign idx_ok    = 32'(entry_index) < 32'(TABLE_DEPTH);
  assign key_in    = pc - base_r;
  assign out_free  = !out_valid_r || out_tready;

  // clamp the record count to 1..TABLE_DEPTH
  always_comb begin
    if (count_r == '0) begin
      cnt32 = 32'd1;
    end else if (32'(count_r) > 32'(TABLE_DEPTH)) begin
      cnt32 = 32'(TABLE_DEPTH);
    end else begin
      cnt32 = 32'(count_r);
    end
  end
  assign hi_init = IDX_W'(cnt32 - 32'd1);

  // loads go straight to the table
  assign ram_we    = in_acc && (req_type == REQ_LOAD) && idx_ok;
  assign ram_waddr = IDX_W'(entry_index);
  assign ram_wdata = {entry_line, entry_offset};

  // search sequencer: one probe per cycle, next address from the compare
  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    impl_nxt      = impl_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    lo_c          = lo_r;
    hi_c          = hi_r;
    mid_sum       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (req_type == REQ_QUERY)) begin
          key_nxt  = key_in;
          impl_nxt = has_impl_r && (key_in >= impl_off_r);
          lo_nxt   = '0;
          hi_nxt   = hi_init;
          ram_re   = 1'b1;
          if (hi_init != '0) begin
            mid_sum   = ({1'b0, hi_init} + (IDX_W+1)'(1)) >> 1;
            mid_nxt   = mid_sum[IDX_W-1:0];
            ram_raddr = mid_sum[IDX_W-1:0];
            state_nxt = S_CMP;
          end else begin
            ram_raddr = '0;
            state_nxt = S_LINE;
          end
        end
      end
      S_CMP: begin
        if (ram_rdata[OFF_W-1:0] <= key_r) begin
          lo_c = mid_r;
        end else begin
          hi_c = mid_r - IDX_W'(1);
        end
        lo_nxt = lo_c;
        hi_nxt = hi_c;
        ram_re = 1'b1;
        if (lo_c < hi_c) begin
          mid_sum   = ({1'b0, lo_c} + {1'b0, hi_c} + (IDX_W+1)'(1)) >> 1;
          mid_nxt   = mid_sum[IDX_W-1:0];
          ram_raddr = mid_sum[IDX_W-1:0];
        end else begin
          ram_raddr = lo_c;
          state_nxt = S_LINE;
        end
      end
      S_LINE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({impl_r, EIDX_W'(lo_r),
                                       ram_rdata[REC_W-1:OFF_W]});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    impl_r     <= impl_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  pcl_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // search window stays ordered while probing
  a_window_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (lo_r < hi_r) && (mid_r > lo_r) && (mid_r <= hi_r))
    else $error("probe window out of order");

  // a query leaves idle in the next cycle
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (req_type == REQ_QUERY)) |=> (state_r != S_IDLE))
    else $error("query did not start a search");

  // a load never starts a search
  a_load_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (req_type == REQ_LOAD)) |=> (state_r == S_IDLE))
    else $error("load left idle");

  // the result register is only overwritten once it has been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LINE && out_valid_r && !out_tready) |=> (state_r == S_LINE))
    else $error("result dropped under stall");

endmodule
`default_nettype wire

// ===== sv/pcl_ram.sv =====
`default_nettype none
module pcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== verif/pc_to_line_lookup_top_tb.sv =====
`timescale 1ns / 100ps
module pc_to_line_lookup_top_tb;
  import pcl_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int QUERY_TARGET  = 120;
  localparam int MAX_REPORTS   = 100;

  // one input beat, unpacked
  typedef struct packed {
    logic              kind;
    logic [EIDX_W-1:0] idx;
    logic [OFF_W-1:0]  off;
    logic [LINE_W-1:0] line;
    logic [OFF_W-1:0]  pc;
  } line_req_t;

  // one lookup answer
  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [EIDX_W-1:0] slot;
    logic              impl;
  } line_hit_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // in tdata: entry_index, entry_offset, entry_line, pc, zero pad
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // in tuser: req_type
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // out tdata: line_number, found_index, in_impl_part, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [3:0]            cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  // shadow of the line table and registers
  logic [OFF_W-1:0]  tbl_off [TABLE_DEPTH];
  logic [LINE_W-1:0] tbl_line [TABLE_DEPTH];
  logic [31:0]       base_q = '0;
  logic [CNT_W-1:0]  count_q = 11'd1;
  logic              has_impl_q = 1'b0;
  logic [31:0]       impl_off_q = '0;

  line_req_t req_pending[$];
  line_hit_t hit_expect[$];
  line_req_t req_live;
  int        errors = 0;
  int        cycles = 0;
  logic      calm;

  pc_to_line_lookup_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no idling on either side inside this window
  assign calm = (cycles >= 1500) && (cycles < 3000);

  // binary predecessor search over the shadow table
  function automatic line_hit_t lookup_line(logic [OFF_W-1:0] pc);
    line_hit_t        r;
    logic [OFF_W-1:0] key;
    int               n, lo, hi, mid;
    key = pc - base_q;
    n = count_q;
    if (n == 0) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (tbl_off[mid] <= key) lo = mid;
      else hi = mid - 1;
    end
    r.line = tbl_line[lo];
    r.slot = EIDX_W'(lo);
    r.impl = has_impl_q && (key >= impl_off_q);
    return r;
  endfunction

  task automatic put_load(int slot, logic [OFF_W-1:0] off, logic [LINE_W-1:0] line);
    line_req_t b;
    b.kind = REQ_LOAD;
    b.idx = EIDX_W'(slot);
    b.off = off;
    b.line = line;
    b.pc = $urandom;
    req_pending.push_back(b);
  endtask

  task automatic put_query(logic [OFF_W-1:0] pc);
    line_req_t b;
    b.kind = REQ_QUERY;
    b.idx = EIDX_W'($urandom);
    b.off = $urandom;
    b.line = LINE_W'($urandom);
    b.pc = pc;
    req_pending.push_back(b);
  endtask

  // wait until every beat is taken and every answer is back
  task automatic drain();
    do @(negedge clk);
    while (req_pending.size() != 0 || in_tvalid || hit_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // apb write, only while the block is idle
  task automatic write_reg(logic [1:0] r, logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {r, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (r)
      REG_BASE: base_q = v;
      REG_COUNT: count_q = v[CNT_W-1:0];
      REG_HAS: has_impl_q = v[0];
      REG_IMPL: impl_off_q = v;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // input driver: updates the shadow on every accepted load and queues the expected answer for every accepted query
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (req_live.kind == REQ_LOAD) begin
          tbl_off[req_live.idx] = req_live.off;
          tbl_line[req_live.idx] = req_live.line;
        end else begin
          hit_expect.push_back(lookup_line(req_live.pc));
        end
      end
      if (!in_tvalid || in_tready) begin
        if (req_pending.size() > 0 && (calm || $urandom_range(99) >= 25)) begin
          req_live = req_pending.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= req_live.kind;
          in_tdata <= {{(IN_DATA_W - 98){1'b0}}, req_live.pc, req_live.line,
                       req_live.off, req_live.idx};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    line_hit_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.line = out_tdata[23:0];
        got.slot = out_tdata[33:24];
        got.impl = out_tdata[34];
        if (hit_expect.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected beat line %h slot %0d impl %0b",
                     $time, got.line, got.slot, got.impl);
        end else begin
          want = hit_expect.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: exp line %h slot %0d impl %0b got line %h slot %0d impl %0b",
                       $time, want.line, want.slot, want.impl, got.line, got.slot, got.impl);
          end
        end
      end
      out_tready <= calm || ($urandom_range(99) >= 25);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [OFF_W-1:0] offs [TABLE_DEPTH];
    logic [31:0]      span, acc, pc, base_sel, impl, off;
    int               n, nq, queries, phase, pick, slot;
    logic             scramble;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, one record with the largest line
    put_load(0, 32'h0, 24'hFFFFFF);
    put_query(32'h0);
    put_query(32'hFFFFFFFF);
    drain();

    // four records, impl part on, edges around some offsets
    write_reg(REG_BASE, 32'h1000);
    write_reg(REG_COUNT, 32'd4);
    write_reg(REG_HAS, 32'd1);
    write_reg(REG_IMPL, 32'h30);
    put_load(0, 32'h10, 24'd1);
    put_load(1, 32'h20, 24'd2);
    put_load(2, 32'h30, 24'd3);
    put_load(3, 32'hFFFFFFFF, 24'd0);
    put_query(32'h1000);   // below every record
    put_query(32'h1010);
    put_query(32'h102F);
    put_query(32'h1030);   // first impl offset
    put_query(32'h0FFF);   // pc below base wraps
    put_query(32'h0);
    drain();

    // zero count behaves as one record
    write_reg(REG_COUNT, 32'd0);
    put_query(32'h1025);
    drain();

    // unsorted table
    write_reg(REG_COUNT, 32'd4);
    put_load(1, 32'hFFFF0000, 24'h123456);
    put_query(32'h1035);
    put_query(32'h1015);

    // random phases: fresh table, settings, then targeted queries
    queries = 0;
    phase = 0;
    while (queries < QUERY_TARGET) begin
      drain();
      if (phase == 0) n = TABLE_DEPTH;
      else if ($urandom_range(11) == 0) n = $urandom_range(300, 1);
      else n = $urandom_range(24, 1);
      pick = $urandom_range(5);
      base_sel = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFFFFFF : 32'($urandom);
      write_reg(REG_BASE, base_sel);
      // first phase saturates an oversized count
      write_reg(REG_COUNT, (phase == 0) ? 32'h7FF : 32'(n));
      write_reg(REG_HAS, 32'($urandom_range(1)));

      // sorted offsets by bounded gaps, sometimes scrambled
      scramble = (phase != 0) && ($urandom_range(5) == 0);
      span = 32'hFFFFFFFF / (n + 1);
      acc = $urandom_range(span);
      for (int i = 0; i < n; i++) begin
        offs[i] = scramble ? 32'($urandom) : acc;
        acc = acc + $urandom_range(span);
      end

      // impl offset goes in before the table beats are queued
      pick = $urandom_range(4);
      impl = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFFFFFF :
             (pick == 2) ? 32'($urandom) : offs[$urandom_range(n - 1)];
      write_reg(REG_IMPL, impl);

      for (int i = 0; i < n; i++) begin
        put_load(i, offs[i], LINE_W'($urandom));
      end

      for (int pass = 0; pass < ((phase == 0) ? 2 : 1); pass++) begin
        if (pass == 1) begin
          drain();
          write_reg(REG_COUNT, 32'(TABLE_DEPTH));
        end
        nq = $urandom_range(40, 10);
        for (int q = 0; q < nq; q++) begin
          pick = $urandom_range(9);
          if (pick < 6) pc = base_sel + offs[$urandom_range(n - 1)] + $urandom_range(2) - 1;
          else if (pick < 8) pc = $urandom;
          else pc = base_sel + impl + $urandom_range(2) - 1;
          put_query(pc);
          // occasional stray load that may break the ordering
          if ($urandom_range(19) == 0) begin
            slot = $urandom_range(TABLE_DEPTH - 1);
            off = $urandom;
            if (slot < n) offs[slot] = off;
            put_load(slot, off, LINE_W'($urandom));
          end
        end
        queries += nq;
      end
      phase++;
    end

    drain();
    errors += hit_expect.size();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pcl_pkg.sv
sv/pcl_ram.sv
sv/pc_to_line_lookup_top.sv
verif/pc_to_line_lookup_top_tb.sv
